@@ rtl/angle_window_rate_sensor_core_assert.svh @@
// assertion macros used by the angle window rate sensor core
`ifndef ANGLE_WINDOW_RATE_SENSOR_CORE_ASSERT_SVH
`define ANGLE_WINDOW_RATE_SENSOR_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define AWRS_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("awrs assertion failed");

// next-cycle implication
`define AWRS_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("awrs assertion failed");

`else

`define AWRS_ASSERT_IMP(label, clk, rst_n, pre, post)

`define AWRS_ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ rtl/awrs_pkg.sv @@
// types and constants of the angle window rate sensor
package awrs_pkg;

    localparam int ANGLE_W    = 16;
    localparam int CHANGE_W   = 23;
    localparam int VOLT_W     = 23;
    localparam int WIN_W      = 7;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 2 * ANGLE_W;
    localparam int PROD_W     = GAIN_W + 1 + CHANGE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int HISTORY_DEPTH_DEFAULT = 128;

    localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RESET = 7'd10;
    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RESET  = 16'd942;
    localparam logic [VOLT_W-1:0] STANDBY_OFFSET_RESET = 23'd1350000;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY_OFFSET = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_LOAD,
        S_ACC,
        S_VROLL,
        S_VPITCH,
        S_VDONE
    } state_t;

    // control from the sequencer to the voltage unit
    typedef struct packed {
        logic en;
        logic sel_pitch;
    } volt_ctrl_t;

endpackage

@@ rtl/awrs_if.sv @@
// valid/ready channels of the angle window rate sensor

interface awrs_sample_if import awrs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;

    modport source (output valid, output roll_angle, output pitch_angle, input ready);
    modport sink (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

interface awrs_result_if import awrs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [CHANGE_W-1:0] roll_change;
    logic signed [CHANGE_W-1:0] pitch_change;
    logic        [VOLT_W-1:0]   roll_voltage_uv;
    logic        [VOLT_W-1:0]   pitch_voltage_uv;

    modport source (output valid, output roll_change, output pitch_change,
                    output roll_voltage_uv, output pitch_voltage_uv, input ready);
    modport sink (input valid, input roll_change, input pitch_change,
                  input roll_voltage_uv, input pitch_voltage_uv, output ready);
endinterface

interface awrs_cfg_if import awrs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/awrs_hist.sv @@
// ring history memory of roll and pitch samples with fill tracking
module awrs_hist import awrs_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [SAMPLE_W-1:0]              wr_data,
    output logic [$clog2(HISTORY_DEPTH)-1:0] wr_ptr,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    output logic [SAMPLE_W-1:0]              rd_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       wr_ptr_reg;
    logic [FW-1:0]       fill_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // entries are written in ring order, so the fill count tells which were ever written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (FW'(rd_addr) < fill_reg);
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                if (fill_reg < FW'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    assign wr_ptr  = wr_ptr_reg;
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/awrs_volt.sv @@
// shared gain multiplier with offset add and saturation
module awrs_volt import awrs_pkg::*; (
    input  logic                       clk,
    input  volt_ctrl_t                 ctrl,
    input  logic signed [CHANGE_W-1:0] roll_change,
    input  logic signed [CHANGE_W-1:0] pitch_change,
    input  logic [GAIN_W-1:0]          gain,
    input  logic [VOLT_W-1:0]          offset,
    output logic [VOLT_W-1:0]          voltage
);

    localparam int SH_W  = PROD_W - 8;
    localparam int SUM_W = SH_W + 1;

    logic signed [PROD_W-1:0]   product_reg;
    logic signed [CHANGE_W-1:0] change;
    logic signed [SH_W-1:0]     scaled;
    logic signed [SUM_W-1:0]    sum;

    assign change = ctrl.sel_pitch ? pitch_change : roll_change;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            product_reg <= $signed({1'b0, gain}) * change;
        end
    end

    // arithmetic shift floors the q8 product
    assign scaled = product_reg[PROD_W-1:8];
    assign sum    = {scaled[SH_W-1], scaled} + SUM_W'(offset);

    always_comb
    begin
        priority if (sum[SUM_W-1])
        begin
            voltage = '0;
        end
        else if (|sum[SUM_W-2:VOLT_W])
        begin
            voltage = '1;
        end
        else
        begin
            voltage = sum[VOLT_W-1:0];
        end
    end

endmodule

@@ rtl/angle_window_rate_sensor_core.sv @@
// angle window rate sensor: roll/pitch change over a window and gyro voltages
// a request walks min(window_length, HISTORY_DEPTH-1) history steps, then forms both voltages
// (a zero window goes straight to the voltages); one request at a time, the next is accepted
// once the previous result is in the output register, later while a held result is not taken
// the history memory read port sets the pace: one sample read per cycle of the window
// reset clears history through a fill count (no clearing pass), registers to their defaults
`include "angle_window_rate_sensor_core_assert.svh"
module angle_window_rate_sensor_core import awrs_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    awrs_sample_if.sink   sample,
    awrs_result_if.source result,
    awrs_cfg_if.sink      cfg
);

    localparam int AW      = $clog2(HISTORY_DEPTH);
    localparam int WIN_MAX = HISTORY_DEPTH - 1;

    state_t state_reg, state_next;

    logic [WIN_W-1:0]           window_length_reg;
    logic [GAIN_W-1:0]          voltage_gain_reg;
    logic [VOLT_W-1:0]          standby_offset_reg;

    logic [AW-1:0]              addr_reg;
    logic [WIN_W-1:0]           cnt_reg;
    logic [SAMPLE_W-1:0]        prev_reg;
    logic signed [CHANGE_W-1:0] roll_acc_reg;
    logic signed [CHANGE_W-1:0] pitch_acc_reg;
    logic [VOLT_W-1:0]          roll_volt_reg;

    logic                       out_valid_reg;
    logic signed [CHANGE_W-1:0] out_roll_change_reg;
    logic signed [CHANGE_W-1:0] out_pitch_change_reg;
    logic [VOLT_W-1:0]          out_roll_volt_reg;
    logic [VOLT_W-1:0]          out_pitch_volt_reg;

    logic                       accept;
    logic                       load_out;
    logic [WIN_W-1:0]           win;
    logic [AW-1:0]              wr_ptr;
    logic [AW:0]                start_sum;
    logic [AW-1:0]              start_pos;
    logic [AW-1:0]              addr_inc;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [ANGLE_W-1:0]  roll_diff;
    logic signed [ANGLE_W-1:0]  pitch_diff;
    volt_ctrl_t                 volt_ctrl;
    logic [VOLT_W-1:0]          volt_q;

    awrs_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data ({sample.pitch_angle, sample.roll_angle}),
        .wr_ptr  (wr_ptr),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    awrs_volt u_volt (
        .clk          (clk),
        .ctrl         (volt_ctrl),
        .roll_change  (roll_acc_reg),
        .pitch_change (pitch_acc_reg),
        .gain         (voltage_gain_reg),
        .offset       (standby_offset_reg),
        .voltage      (volt_q)
    );

    assign accept   = sample.valid && sample.ready;
    assign load_out = !out_valid_reg || result.ready;

    always_comb
    begin
        if (int'(window_length_reg) > WIN_MAX)
        begin
            win = WIN_W'(WIN_MAX);
        end
        else
        begin
            win = window_length_reg;
        end
    end

    // oldest sample of the window, the one just written sits at wr_ptr
    assign start_sum = {1'b0, wr_ptr} + (AW+1)'(HISTORY_DEPTH) - {1'b0, AW'(win)};
    assign start_pos = (start_sum >= (AW+1)'(HISTORY_DEPTH))
                       ? AW'(start_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(start_sum);
    assign addr_inc  = (addr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : addr_reg + 1'b1;

    // modular difference read as signed gives the wrap correction
    assign roll_diff  = $signed(rd_data[ANGLE_W-1:0] - prev_reg[ANGLE_W-1:0]);
    assign pitch_diff = $signed(rd_data[SAMPLE_W-1:ANGLE_W] - prev_reg[SAMPLE_W-1:ANGLE_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        sample.ready        = 1'b0;
        volt_ctrl.en        = 1'b0;
        volt_ctrl.sel_pitch = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    state_next = (win == '0) ? S_VROLL : S_PRIME;
                end
            end
            S_PRIME:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (cnt_reg == WIN_W'(1))
                begin
                    state_next = S_VROLL;
                end
            end
            S_VROLL:
            begin
                volt_ctrl.en = 1'b1;
                state_next   = S_VPITCH;
            end
            S_VPITCH:
            begin
                volt_ctrl.en        = 1'b1;
                volt_ctrl.sel_pitch = 1'b1;
                state_next          = S_VDONE;
            end
            S_VDONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                addr_reg      <= start_pos;
                cnt_reg       <= win;
                roll_acc_reg  <= '0;
                pitch_acc_reg <= '0;
            end
            S_PRIME:
            begin
                addr_reg <= addr_inc;
            end
            S_LOAD:
            begin
                prev_reg <= rd_data;
                addr_reg <= addr_inc;
            end
            S_ACC:
            begin
                prev_reg      <= rd_data;
                addr_reg      <= addr_inc;
                cnt_reg       <= cnt_reg - 1'b1;
                roll_acc_reg  <= roll_acc_reg + CHANGE_W'(roll_diff);
                pitch_acc_reg <= pitch_acc_reg + CHANGE_W'(pitch_diff);
            end
            S_VPITCH:
            begin
                roll_volt_reg <= volt_q;
            end
            S_VDONE:
            begin
                if (load_out)
                begin
                    out_roll_change_reg  <= roll_acc_reg;
                    out_pitch_change_reg <= pitch_acc_reg;
                    out_roll_volt_reg    <= roll_volt_reg;
                    out_pitch_volt_reg   <= volt_q;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_VDONE && load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg  <= WINDOW_LENGTH_RESET;
            voltage_gain_reg   <= VOLTAGE_GAIN_RESET;
            standby_offset_reg <= STANDBY_OFFSET_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_WINDOW_LENGTH:  window_length_reg  <= cfg.data[WIN_W-1:0];
                REG_VOLTAGE_GAIN:   voltage_gain_reg   <= cfg.data[GAIN_W-1:0];
                REG_STANDBY_OFFSET: standby_offset_reg <= cfg.data[VOLT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    assign result.valid            = out_valid_reg;
    assign result.roll_change      = out_roll_change_reg;
    assign result.pitch_change     = out_pitch_change_reg;
    assign result.roll_voltage_uv  = out_roll_volt_reg;
    assign result.pitch_voltage_uv = out_pitch_volt_reg;

    `AWRS_ASSERT_IMP(a_acc_cnt_live, clk, rst_n, state_reg == S_ACC, cnt_reg != '0)
    `AWRS_ASSERT_IMP(a_acc_cnt_bound, clk, rst_n, state_reg == S_ACC, int'(cnt_reg) <= WIN_MAX)
    `AWRS_ASSERT_NXT(a_accept_next, clk, rst_n, accept, state_reg == S_PRIME || state_reg == S_VROLL)
    `AWRS_ASSERT_NXT(a_out_hold, clk, rst_n, state_reg == S_VDONE && out_valid_reg && !result.ready, state_reg == S_VDONE && out_valid_reg)

endmodule
